/* hw/rtl/blg_pkg.sv */
package blg_pkg;

  localparam int LEVEL_W     = 4;
  localparam int MV_W        = 14;
  localparam int MV_FULL_W   = 15;
  localparam int VOLT_W      = 20;
  localparam int THR_W       = 13;
  localparam int LEVEL_COUNT = 10;
  localparam int REF_MV_W    = 11;
  localparam int HYST_W      = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_MV  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_MV = 1'b1;

  localparam logic [REF_MV_W-1:0] REF_MV_RESET = 11'd1200;
  localparam logic [HYST_W-1:0]   HYST_RESET   = 6'd5;
  localparam logic [LEVEL_W-1:0]  LEVEL_FULL   = 4'd10;
  localparam logic [VOLT_W-1:0]   VOLT_MAX     = 20'hFFFFF;
  localparam logic [MV_W-1:0]     CELL_MV_MAX  = 14'h3FFF;

  // node = ref_mV * 2^16 * bat_avg / (MV_PER_VOLT * ref_avg)
  localparam int MV_PER_VOLT = 1000;
  // cell mV = (filtered * CELL_SCALE) >> 16, i.e. 2 * 1000 * volts
  localparam logic [10:0] CELL_SCALE = 11'd2000;
  // 0.8/0.2 smoothing: (4 * old + new) / FILT_DIV
  localparam logic [2:0]  FILT_DIV   = 3'd5;

  function automatic logic [THR_W-1:0] level_thr_mv(input logic [LEVEL_W-1:0] idx);
    logic [THR_W-1:0] thr;
    unique case (idx)
      4'd0:    thr = 13'd3680;
      4'd1:    thr = 13'd3740;
      4'd2:    thr = 13'd3770;
      4'd3:    thr = 13'd3790;
      4'd4:    thr = 13'd3820;
      4'd5:    thr = 13'd3870;
      4'd6:    thr = 13'd3920;
      4'd7:    thr = 13'd3980;
      4'd8:    thr = 13'd4060;
      4'd9:    thr = 13'd4160;
      default: thr = '1;
    endcase
    return thr;
  endfunction

endpackage

/* hw/rtl/battery_level_gauge_unit.sv */
// Battery charge gauge. Each input word is one conversion set (battery divider
// sample, internal reference sample) and yields exactly one output word with
// the held level (0..10), an update flag and the filtered cell voltage in mV.
// The front end sums WINDOW_LENGTH sets and hands each word to the back end
// through a two-word queue, so input is taken while the back end is busy.
// With the back end idle, a word that does not close a window goes from the queue
// to the output register, and while the output is not stalled such words pass
// at one per cycle. The word that arrives after a full window closes it: both
// averages and the smoothing step are reciprocal multiplies, and only the node
// voltage goes through the restoring divider, which is skipped when the node
// voltage saturates. Once the queue holds one more word, input stalls until
// the closing word leaves.
// Configuration (index 0: reference mV, index 1: hysteresis mV) is always
// ready and is to be written only while no word is in flight.
module battery_level_gauge_unit #(
  parameter int WINDOW_LENGTH = 64,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           in_battery_sample,
  input  logic [SAMPLE_BITS-1:0]           in_reference_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [blg_pkg::LEVEL_W-1:0]      out_charge_level,
  output logic                             out_level_updated,
  output logic [blg_pkg::MV_W-1:0]         out_cell_millivolts,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [blg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import blg_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
  localparam int QD_W   = 1 + 2 * SUM_W;

  logic [REF_MV_W-1:0] ref_mv_r, ref_mv_nxt;
  logic [HYST_W-1:0]   hyst_r, hyst_nxt;

  logic              push;
  logic              push_close;
  logic [SUM_W-1:0]  push_bsum;
  logic [SUM_W-1:0]  push_rsum;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [QD_W-1:0]   q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    ref_mv_nxt = ref_mv_r;
    hyst_nxt   = hyst_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_REFERENCE_MV:  ref_mv_nxt = cfg_data[REF_MV_W-1:0];
        REG_HYSTERESIS_MV: hyst_nxt   = cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_mv_r <= REF_MV_RESET;
      hyst_r   <= HYST_RESET;
    end else begin
      ref_mv_r <= ref_mv_nxt;
      hyst_r   <= hyst_nxt;
    end
  end

  blg_front #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_battery_sample   (in_battery_sample),
    .in_reference_sample (in_reference_sample),
    .push                (push),
    .push_close          (push_close),
    .push_bsum           (push_bsum),
    .push_rsum           (push_rsum),
    .q_full              (q_full)
  );

  blg_queue #(
    .DATA_W (QD_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_close, push_bsum, push_rsum}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  blg_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_close             (q_head[QD_W-1]),
    .q_bsum              (q_head[2*SUM_W-1:SUM_W]),
    .q_rsum              (q_head[SUM_W-1:0]),
    .q_pop               (q_pop),
    .ref_mv              (ref_mv_r),
    .hyst_mv             (hyst_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_charge_level    (out_charge_level),
    .out_level_updated   (out_level_updated),
    .out_cell_millivolts (out_cell_millivolts)
  );

endmodule

/* hw/rtl/blg_front.sv */
module blg_front #(
  parameter int WINDOW_LENGTH = 64,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_valid,
  output logic                                                in_stall,
  input  logic [SAMPLE_BITS-1:0]                              in_battery_sample,
  input  logic [SAMPLE_BITS-1:0]                              in_reference_sample,
  output logic                                                push,
  output logic                                                push_close,
  output logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]        push_bsum,
  output logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]        push_rsum,
  input  logic                                                q_full
);

  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
  localparam logic [CNT_W-1:0] WIN = CNT_W'(WINDOW_LENGTH);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] bsum_r, bsum_nxt;
  logic [SUM_W-1:0] rsum_r, rsum_nxt;
  logic             accept;
  logic             close;

  assign in_stall   = q_full;
  assign accept     = in_valid & ~q_full;
  assign close      = (count_r == WIN);
  assign push       = accept;
  assign push_close = close;
  assign push_bsum  = bsum_r;
  assign push_rsum  = rsum_r;

  always_comb begin
    count_nxt = count_r;
    bsum_nxt  = bsum_r;
    rsum_nxt  = rsum_r;
    if (accept) begin
      if (close) begin
        // this word opens the next window
        count_nxt = CNT_W'(1);
        bsum_nxt  = SUM_W'(in_battery_sample);
        rsum_nxt  = SUM_W'(in_reference_sample);
      end else begin
        count_nxt = count_r + 1'b1;
        bsum_nxt  = bsum_r + SUM_W'(in_battery_sample);
        rsum_nxt  = rsum_r + SUM_W'(in_reference_sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bsum_r  <= '0;
      rsum_r  <= '0;
    end else begin
      count_r <= count_nxt;
      bsum_r  <= bsum_nxt;
      rsum_r  <= rsum_nxt;
    end
  end

endmodule

/* hw/rtl/blg_queue.sv */
module blg_queue #(
  parameter int DATA_W = 37
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/blg_div.sv */
// Restoring divider, one quotient bit per cycle.
// Caller guarantees dividend < divisor * 2^Q_W and divisor != 0.
module blg_div #(
  parameter int DVD_W = 39,
  parameter int DVS_W = 22,
  parameter int Q_W   = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(Q_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [Q_W-1:0]    lo_r, lo_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial    = {rem_r, lo_r[Q_W-1]};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = DVS_W'(dividend >> Q_W);
      lo_nxt   = dividend[Q_W-1:0];
      dvs_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      lo_nxt   = {lo_r[Q_W-2:0], 1'b0};
      quo_nxt  = {quo_r[Q_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
  end

endmodule

/* hw/rtl/blg_back.sv */
module blg_back #(
  parameter int WINDOW_LENGTH = 64,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_valid,
  input  logic                                          q_close,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]  q_bsum,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]  q_rsum,
  output logic                                          q_pop,
  input  logic [blg_pkg::REF_MV_W-1:0]                  ref_mv,
  input  logic [blg_pkg::HYST_W-1:0]                    hyst_mv,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [blg_pkg::LEVEL_W-1:0]                   out_charge_level,
  output logic                                          out_level_updated,
  output logic [blg_pkg::MV_W-1:0]                      out_cell_millivolts
);

  import blg_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = SB + $clog2(WINDOW_LENGTH);
  localparam int NUM_W  = REF_MV_W + SB + 16;
  localparam int DEN_W  = SB + 10;
  localparam int PROD_W = REF_MV_W + SB;
  localparam int FSUM_W = VOLT_W + 3;
  localparam int CELL_W = VOLT_W + 11;

  // floor(sum / WINDOW_LENGTH) = (sum * AVG_RECIP) >> AVG_SH for any sum below 2^SUM_W
  localparam int AVG_SH = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int AVG_RW = SUM_W + 1;
  localparam int AVG_PW = SUM_W + AVG_RW;
  localparam longint unsigned AVG_RECIP_L =
    ((64'd1 << AVG_SH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [AVG_RW-1:0] AVG_RECIP = AVG_RW'(AVG_RECIP_L);

  // same trick for the divide by FILT_DIV in the smoothing step
  localparam int FILT_SH = FSUM_W + $clog2(FILT_DIV);
  localparam int FILT_RW = FSUM_W + 1;
  localparam int FILT_PW = FSUM_W + FILT_RW;
  localparam longint unsigned FILT_RECIP_L =
    ((64'd1 << FILT_SH) + 64'(FILT_DIV) - 64'd1) / 64'(FILT_DIV);
  localparam logic [FILT_RW-1:0] FILT_RECIP = FILT_RW'(FILT_RECIP_L);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AVGB  = 4'd1;
  localparam logic [3:0] S_AVGR  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_NSAT  = 4'd4;
  localparam logic [3:0] S_NWAIT = 4'd5;
  localparam logic [3:0] S_FILT  = 4'd6;
  localparam logic [3:0] S_CELL  = 4'd7;
  localparam logic [3:0] S_LEVEL = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]           state_r, state_nxt;
  logic [VOLT_W-1:0]    filt_r, filt_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  logic [MV_FULL_W-1:0] mv_full_r, mv_full_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [SB-1:0]        bavg_r, bavg_nxt;
  logic [SB-1:0]        ravg_r, ravg_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [VOLT_W-1:0]    node_r, node_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;
  logic                 out_upd_r, out_upd_nxt;
  logic [MV_W-1:0]      out_mv_r, out_mv_nxt;

  logic                 div_start;
  logic [NUM_W-1:0]     div_dvd;
  logic [DEN_W-1:0]     div_dvs;
  logic                 div_done;
  logic [VOLT_W-1:0]    div_quo;

  logic                 slot_free;
  logic                 load;
  logic                 load_upd;
  logic [SUM_W-1:0]     avg_src;
  logic [AVG_PW-1:0]    avg_prod;
  logic [SB-1:0]        avg_q;
  logic [PROD_W-1:0]    prod;
  logic [DEN_W+VOLT_W-1:0] den_sh;
  logic                 node_sat;
  logic [FSUM_W-1:0]    filt_sum;
  logic [FILT_PW-1:0]   filt_prod;
  logic [VOLT_W-1:0]    filt_q;
  logic [CELL_W-1:0]    cell_prod;
  logic [MV_W-1:0]      mv_sat;
  logic [LEVEL_COUNT-1:0] reach_dn;
  logic [LEVEL_COUNT-1:0] reach_up;
  logic [LEVEL_W-1:0]   lv_dn;
  logic [LEVEL_W-1:0]   lv_up;
  logic [LEVEL_W-1:0]   lv_low;

  blg_div #(
    .DVD_W (NUM_W),
    .DVS_W (DEN_W),
    .Q_W   (VOLT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign slot_free = ~out_valid_r | ~out_stall;
  // one shared multiplier for both window averages
  assign avg_src   = (state_r == S_AVGR) ? q_rsum : q_bsum;
  assign avg_prod  = AVG_PW'(avg_src) * AVG_PW'(AVG_RECIP);
  assign avg_q     = avg_prod[AVG_SH +: SB];
  assign prod      = {{SB{1'b0}}, ref_mv} * {{REF_MV_W{1'b0}}, bavg_r};
  assign den_sh    = {den_r, {VOLT_W{1'b0}}};
  // zero divisor lands here as well since den_sh is then zero
  assign node_sat  = ((DEN_W+VOLT_W)'(num_r) >= den_sh);
  assign filt_sum  = FSUM_W'({filt_r, 2'b00}) + FSUM_W'(node_r);
  assign filt_prod = FILT_PW'(filt_sum) * FILT_PW'(FILT_RECIP);
  assign filt_q    = filt_prod[FILT_SH +: VOLT_W];
  assign cell_prod = CELL_W'(filt_r) * CELL_W'(CELL_SCALE);
  assign mv_sat    = mv_full_r[MV_FULL_W-1] ? CELL_MV_MAX : mv_full_r[MV_W-1:0];

  // cell >= thr*2^16 is the same as floor(cell/2^16) >= thr
  always_comb begin
    logic [THR_W-1:0] thr;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      thr         = level_thr_mv(LEVEL_W'(i));
      reach_dn[i] = (mv_full_r >= MV_FULL_W'(thr));
      reach_up[i] = (mv_full_r >= MV_FULL_W'(thr) + MV_FULL_W'(hyst_mv));
    end
    lv_dn  = LEVEL_W'($countones(reach_dn));
    lv_up  = LEVEL_W'($countones(reach_up));
    lv_low = (lv_dn < level_r) ? lv_dn : level_r;
  end

  always_comb begin
    state_nxt   = state_r;
    filt_nxt    = filt_r;
    level_nxt   = level_r;
    mv_full_nxt = mv_full_r;
    bavg_nxt    = bavg_r;
    ravg_nxt    = ravg_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    node_nxt    = node_r;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;
    load        = 1'b0;
    load_upd    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_close) begin
            state_nxt = S_AVGB;
          end else if (slot_free) begin
            load = 1'b1;
          end
        end
      end
      S_AVGB: begin
        bavg_nxt  = avg_q;
        state_nxt = S_AVGR;
      end
      S_AVGR: begin
        ravg_nxt  = avg_q;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        num_nxt   = {prod, 16'b0};
        den_nxt   = DEN_W'(ravg_r) * DEN_W'(MV_PER_VOLT);
        state_nxt = S_NSAT;
      end
      S_NSAT: begin
        if (node_sat) begin
          node_nxt  = VOLT_MAX;
          state_nxt = S_FILT;
        end else begin
          div_start = 1'b1;
          div_dvd   = num_r;
          div_dvs   = den_r;
          state_nxt = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (div_done) begin
          node_nxt  = div_quo;
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        // unseeded or decayed to zero: seed with this value
        filt_nxt  = (filt_r == '0) ? node_r : filt_q;
        state_nxt = S_CELL;
      end
      S_CELL: begin
        mv_full_nxt = cell_prod[CELL_W-1:16];
        state_nxt   = S_LEVEL;
      end
      S_LEVEL: begin
        level_nxt = (lv_up > lv_low) ? lv_up : lv_low;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_upd  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign q_pop = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_upd_nxt   = out_upd_r;
    out_mv_nxt    = out_mv_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = level_r;
      out_upd_nxt   = load_upd;
      out_mv_nxt    = mv_sat;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filt_r      <= '0;
      level_r     <= LEVEL_FULL;
      mv_full_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filt_r      <= filt_nxt;
      level_r     <= level_nxt;
      mv_full_r   <= mv_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bavg_r      <= bavg_nxt;
    ravg_r      <= ravg_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    node_r      <= node_nxt;
    out_level_r <= out_level_nxt;
    out_upd_r   <= out_upd_nxt;
    out_mv_r    <= out_mv_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_charge_level    = out_level_r;
  assign out_level_updated   = out_upd_r;
  assign out_cell_millivolts = out_mv_r;

endmodule

/* hw/rtl/blg_checker.sv */
module blg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [blg_pkg::LEVEL_W-1:0] out_charge_level,
  input logic                        out_level_updated,
  input logic [blg_pkg::MV_W-1:0]    out_cell_millivolts
);

  import blg_pkg::*;

  logic [LEVEL_W-1:0] last_level_r;
  logic [MV_W-1:0]    last_mv_r;

  // level and voltage as of the last word taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= LEVEL_FULL;
      last_mv_r    <= '0;
    end else if (out_valid && !out_stall) begin
      last_level_r <= out_charge_level;
      last_mv_r    <= out_cell_millivolts;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_charge_level) &&
      $stable(out_level_updated) && $stable(out_cell_millivolts))
    else $error("stalled output word changed");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charge_level <= LEVEL_FULL)
    else $error("charge level above full");

  a_no_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_level_updated |->
      out_charge_level == last_level_r && out_cell_millivolts == last_mv_r)
    else $error("level or voltage moved without a window close");

endmodule

bind battery_level_gauge_unit blg_checker u_blg_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_charge_level    (out_charge_level),
  .out_level_updated   (out_level_updated),
  .out_cell_millivolts (out_cell_millivolts)
);
